>>> rtl/core/itup_pkg.sv
// Shared types, register map and constants for the interrupt/timer/serial register block.
package itup_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register map
  localparam logic [4:0] REG_VECTOR      = 5'd0;
  localparam logic [4:0] REG_LAST_VECTOR = 5'd1;
  localparam logic [4:0] REG_ENABLE_A    = 5'd2;
  localparam logic [4:0] REG_ENABLE_B    = 5'd3;
  localparam logic [4:0] REG_ENABLE_SET  = 5'd4;
  localparam logic [4:0] REG_ENABLE_CLR  = 5'd5;
  localparam logic [4:0] REG_PEND_CLR    = 5'd6;
  localparam logic [4:0] REG_EOI         = 5'd7;
  localparam logic [4:0] REG_TMR_CTRL    = 5'd8;
  localparam logic [4:0] REG_PERIOD      = 5'd9;
  localparam logic [4:0] REG_WD_MODE     = 5'd10;
  localparam logic [4:0] REG_RT_MODE     = 5'd11;
  localparam logic [4:0] REG_TMR_STATUS  = 5'd12;
  localparam logic [4:0] REG_TMR_INT_SET = 5'd13;
  localparam logic [4:0] REG_TMR_INT_CLR = 5'd14;
  localparam logic [4:0] REG_TMR_INT     = 5'd15;
  localparam logic [4:0] REG_RT_ALARM    = 5'd16;
  localparam logic [4:0] REG_RT_COUNT    = 5'd17;
  localparam logic [4:0] REG_SER_CTRL    = 5'd18;
  localparam logic [4:0] REG_SER_MODE    = 5'd19;
  localparam logic [4:0] REG_SER_INT_SET = 5'd20;
  localparam logic [4:0] REG_SER_INT_CLR = 5'd21;
  localparam logic [4:0] REG_SER_INT     = 5'd22;
  localparam logic [4:0] REG_SER_STATUS  = 5'd23;
  localparam logic [4:0] REG_RX_HOLD     = 5'd24;
  localparam logic [4:0] REG_TX          = 5'd25;
  localparam logic [4:0] REG_BAUD        = 5'd26;
  localparam logic [4:0] REG_RX_TMO      = 5'd27;
  localparam logic [4:0] REG_TX_GUARD    = 5'd28;
  localparam logic [4:0] REG_FIDI        = 5'd29;
  localparam logic [4:0] REG_ERR_COUNT   = 5'd30;
  localparam logic [4:0] REG_SER_IF      = 5'd31;

  // Masks and reset values
  localparam logic [31:0] IRQ_MASK        = 32'hffff_fffe;
  localparam logic [19:0] SER_INT_MASK    = 20'hf_3fff;
  localparam logic [31:0] SER_STATUS_RST  = 32'h0000_0202;
  localparam logic [31:0] SER_MODE_RST    = 32'h0000_00c0;
  localparam logic [31:0] UNMAPPED_READ   = 32'hffff_ffff;

  localparam int SYS_INT_BIT_DEF  = 1;
  localparam int UART_INT_BIT_DEF = 6;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;
  localparam int S_TUSER_W = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic        rx_valid;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        irq_active;
    logic        fiq_active;
    logic        tx_valid;
    logic [7:0]  tx_byte;
  } result_t;

  // Index of the lowest set bit, zero when none is set
  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/core/itup_regs.sv
// Register file and per-transaction update logic of the interrupt/timer/serial block.
module itup_regs #(
  parameter int SYS_INT_BIT  = itup_pkg::SYS_INT_BIT_DEF,
  parameter int UART_INT_BIT = itup_pkg::UART_INT_BIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             commit,
  input  itup_pkg::item_t   item,
  output itup_pkg::result_t res
);

  localparam logic [31:0] SYS_MASK  = 32'd1 << SYS_INT_BIT;
  localparam logic [31:0] UART_MASK = 32'd1 << UART_INT_BIT;

  logic [31:0] int_pending, int_pending_next;
  logic [31:0] int_enable, int_enable_next;
  logic [4:0]  last_vector, last_vector_next;
  logic [31:0] period_reload, period_reload_next;
  logic [31:0] period_count, period_count_next;
  logic [3:0]  timer_status, timer_status_next;
  logic [3:0]  timer_int_enable, timer_int_enable_next;
  logic [31:0] wd_mode, wd_mode_next;
  logic [31:0] rt_mode, rt_mode_next;
  logic [31:0] rt_alarm, rt_alarm_next;
  logic [31:0] serial_status, serial_status_next;
  logic [19:0] serial_int_enable, serial_int_enable_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic [31:0] ser_mode, ser_mode_next;
  logic [31:0] ser_baud, ser_baud_next;
  logic [31:0] ser_rx_tmo, ser_rx_tmo_next;
  logic [31:0] ser_tx_guard, ser_tx_guard_next;
  logic [31:0] ser_fidi, ser_fidi_next;
  logic [31:0] ser_if, ser_if_next;

  logic [4:0]  vec;
  logic [31:0] active;

  assign vec = itup_pkg::lowest_set(int_pending);

  always_comb begin
    int_pending_next       = int_pending;
    int_enable_next        = int_enable;
    last_vector_next       = last_vector;
    period_reload_next     = period_reload;
    period_count_next      = period_count;
    timer_status_next      = timer_status;
    timer_int_enable_next  = timer_int_enable;
    wd_mode_next           = wd_mode;
    rt_mode_next           = rt_mode;
    rt_alarm_next          = rt_alarm;
    serial_status_next     = serial_status;
    serial_int_enable_next = serial_int_enable;
    rx_hold_next           = rx_hold;
    ser_mode_next          = ser_mode;
    ser_baud_next          = ser_baud;
    ser_rx_tmo_next        = ser_rx_tmo;
    ser_tx_guard_next      = ser_tx_guard;
    ser_fidi_next          = ser_fidi;
    ser_if_next            = ser_if;
    res                    = '0;

    unique case (item.kind)
      itup_pkg::KIND_READ: begin
        unique case (item.reg_index)
          itup_pkg::REG_VECTOR: begin
            // lowest pending bit, cleared by the read; harmless when nothing pends
            res.read_value   = {27'd0, vec};
            int_pending_next = int_pending & ~(32'd1 << vec);
            last_vector_next = vec;
          end
          itup_pkg::REG_LAST_VECTOR: res.read_value = {27'd0, last_vector};
          itup_pkg::REG_ENABLE_A,
          itup_pkg::REG_ENABLE_B:    res.read_value = int_enable;
          itup_pkg::REG_PERIOD:      res.read_value = period_reload;
          itup_pkg::REG_WD_MODE:     res.read_value = wd_mode;
          itup_pkg::REG_RT_MODE:     res.read_value = rt_mode;
          itup_pkg::REG_TMR_STATUS: begin
            res.read_value    = {28'd0, timer_status};
            timer_status_next = '0;
          end
          itup_pkg::REG_TMR_INT:     res.read_value = {28'd0, timer_int_enable};
          itup_pkg::REG_RT_ALARM:    res.read_value = rt_alarm;
          itup_pkg::REG_RT_COUNT:    res.read_value = '0;
          itup_pkg::REG_SER_MODE:    res.read_value = ser_mode;
          itup_pkg::REG_SER_INT:     res.read_value = {12'd0, serial_int_enable};
          itup_pkg::REG_SER_STATUS:  res.read_value = serial_status;
          itup_pkg::REG_RX_HOLD: begin
            res.read_value        = {24'd0, rx_hold};
            serial_status_next[0] = 1'b0;
          end
          itup_pkg::REG_BAUD:        res.read_value = ser_baud;
          itup_pkg::REG_RX_TMO:      res.read_value = ser_rx_tmo;
          itup_pkg::REG_TX_GUARD:    res.read_value = ser_tx_guard;
          itup_pkg::REG_FIDI:        res.read_value = ser_fidi;
          itup_pkg::REG_ERR_COUNT:   res.read_value = '0;
          itup_pkg::REG_SER_IF:      res.read_value = ser_if;
          default:                   res.read_value = itup_pkg::UNMAPPED_READ;
        endcase
      end

      itup_pkg::KIND_WRITE: begin
        unique case (item.reg_index)
          itup_pkg::REG_ENABLE_SET: int_enable_next = int_enable | item.write_value;
          itup_pkg::REG_ENABLE_CLR: int_enable_next = int_enable & ~item.write_value;
          itup_pkg::REG_PEND_CLR,
          itup_pkg::REG_EOI:        int_pending_next = int_pending & ~item.write_value;
          itup_pkg::REG_PERIOD: begin
            period_reload_next = item.write_value;
            period_count_next  = item.write_value;
          end
          itup_pkg::REG_WD_MODE:    wd_mode_next = item.write_value;
          itup_pkg::REG_RT_MODE:    rt_mode_next = item.write_value;
          itup_pkg::REG_TMR_INT_SET: begin
            timer_int_enable_next = timer_int_enable | item.write_value[3:0];
            if (timer_int_enable_next != '0) begin
              int_pending_next = int_pending | SYS_MASK;
            end
          end
          itup_pkg::REG_TMR_INT_CLR:
            timer_int_enable_next = timer_int_enable & ~item.write_value[3:0];
          itup_pkg::REG_RT_ALARM:   rt_alarm_next = item.write_value;
          itup_pkg::REG_SER_MODE:   ser_mode_next = item.write_value;
          itup_pkg::REG_SER_INT_SET: begin
            serial_int_enable_next = serial_int_enable
                                   | (item.write_value[19:0] & itup_pkg::SER_INT_MASK);
            if (serial_int_enable_next != '0) begin
              int_pending_next = int_pending | UART_MASK;
            end
          end
          itup_pkg::REG_SER_INT_CLR:
            serial_int_enable_next = serial_int_enable & ~item.write_value[19:0]
                                   & itup_pkg::SER_INT_MASK;
          itup_pkg::REG_TX: begin
            res.tx_valid          = 1'b1;
            res.tx_byte           = item.write_value[7:0];
            serial_status_next[1] = 1'b1;
          end
          itup_pkg::REG_BAUD:       ser_baud_next = item.write_value;
          itup_pkg::REG_RX_TMO:     ser_rx_tmo_next = item.write_value;
          itup_pkg::REG_TX_GUARD:   ser_tx_guard_next = item.write_value;
          itup_pkg::REG_FIDI:       ser_fidi_next = item.write_value;
          itup_pkg::REG_SER_IF:     ser_if_next = item.write_value;
          // control registers and read-only registers: write has no effect
          default: ;
        endcase
      end

      itup_pkg::KIND_TICK: begin
        if (period_reload != '0) begin
          if (period_count == '0) begin
            timer_status_next[0] = 1'b1;
            if (timer_int_enable[0]) begin
              int_pending_next = int_pending | SYS_MASK;
            end
            period_count_next = period_reload;
          end else begin
            period_count_next = period_count - 32'd1;
          end
        end
        if (serial_int_enable[0] && item.rx_valid) begin
          rx_hold_next          = item.rx_byte;
          serial_status_next[0] = 1'b1;
          int_pending_next      = int_pending_next | UART_MASK;
        end
      end

      default: ;
    endcase

    active         = int_pending_next & int_enable_next;
    res.irq_active = |(active & itup_pkg::IRQ_MASK);
    res.fiq_active = active[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_pending       <= '0;
      int_enable        <= '0;
      last_vector       <= '0;
      period_reload     <= '0;
      period_count      <= '0;
      timer_status      <= '0;
      timer_int_enable  <= '0;
      wd_mode           <= '0;
      rt_mode           <= '0;
      rt_alarm          <= '0;
      serial_status     <= itup_pkg::SER_STATUS_RST;
      serial_int_enable <= '0;
      rx_hold           <= '0;
      ser_mode          <= itup_pkg::SER_MODE_RST;
      ser_baud          <= itup_pkg::SER_MODE_RST;
      ser_rx_tmo        <= '0;
      ser_tx_guard      <= '0;
      ser_fidi          <= '0;
      ser_if            <= '0;
    end else if (commit) begin
      int_pending       <= int_pending_next;
      int_enable        <= int_enable_next;
      last_vector       <= last_vector_next;
      period_reload     <= period_reload_next;
      period_count      <= period_count_next;
      timer_status      <= timer_status_next;
      timer_int_enable  <= timer_int_enable_next;
      wd_mode           <= wd_mode_next;
      rt_mode           <= rt_mode_next;
      rt_alarm          <= rt_alarm_next;
      serial_status     <= serial_status_next;
      serial_int_enable <= serial_int_enable_next;
      rx_hold           <= rx_hold_next;
      ser_mode          <= ser_mode_next;
      ser_baud          <= ser_baud_next;
      ser_rx_tmo        <= ser_rx_tmo_next;
      ser_tx_guard      <= ser_tx_guard_next;
      ser_fidi          <= ser_fidi_next;
      ser_if            <= ser_if_next;
    end
  end

endmodule

>>> rtl/core/interrupt_timer_uart_peripheral.sv
// Top level: interrupt controller, periodic timer and serial registers behind stream ports.
//
// Input stream (s_axis): one transaction per register read, register write or tick.
//   tuser carries the kind (read, write, tick); tdata carries the register index,
//   write data and the offered receive byte.
// Output stream (m_axis): exactly one result per input transaction, in order:
//   read data, normal and fast interrupt lines after the transaction, and the
//   transmit byte with its valid flag.
// Timing: an accepted transaction sits in the input register, is evaluated against
//   the register file and lands in the output register, from which its result is
//   offered. One transaction per cycle is sustained while m_axis_tready stays high;
//   the rate is set by the combinational update of the register file (a 32-bit
//   lowest-bit search on the pending word is the deepest path).
// Reset: synchronous; both stages empty, registers take their reset values
//   (serial status 0x202, mode and baud 0xc0, all else zero).
// Back-pressure: when m_axis_tready is low the output register holds its result;
//   the input register still takes one more transaction if empty, then s_axis_tready drops.
module interrupt_timer_uart_peripheral #(
  parameter int SYS_INT_BIT  = itup_pkg::SYS_INT_BIT_DEF,
  parameter int UART_INT_BIT = itup_pkg::UART_INT_BIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [4:0] reg_index, [36:5] write_value, [37] rx_valid, [45:38] rx_byte, [47:46] zero
  input  logic [itup_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [itup_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] read_value, [32] irq_active, [33] fiq_active, [34] tx_valid,
  // [42:35] tx_byte, [47:43] zero
  output logic [itup_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic              in_valid;
  itup_pkg::item_t   in_item;
  logic              out_valid;
  itup_pkg::result_t out_res;
  itup_pkg::result_t res;
  logic              advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.kind        <= s_axis_tuser[1:0];
      in_item.reg_index   <= s_axis_tdata[4:0];
      in_item.write_value <= s_axis_tdata[36:5];
      in_item.rx_valid    <= s_axis_tdata[37];
      in_item.rx_byte     <= s_axis_tdata[45:38];
    end
  end

  itup_regs #(
    .SYS_INT_BIT  (SYS_INT_BIT),
    .UART_INT_BIT (UART_INT_BIT)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (in_item),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.tx_byte, out_res.tx_valid, out_res.fiq_active,
                          out_res.irq_active, out_res.read_value};

endmodule

>>> rtl/core/itup_checker.sv
// Port-level checks for the interrupt/timer/serial block, bound to the top level.
module itup_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [itup_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [itup_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [itup_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // output stage comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // a transmit write is a write, so no read data may come with it
  a_tx_no_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("read data alongside a transmit byte");

  a_tx_byte_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[34] |-> m_axis_tdata[42:35] == 8'd0)
    else $error("transmit byte set without transmit valid");

endmodule

bind interrupt_timer_uart_peripheral itup_checker u_itup_checker (.*);

>>> tb/interrupt_timer_uart_peripheral_tb.sv
// Self-checking testbench for the interrupt, timer and serial register block.
module interrupt_timer_uart_peripheral_tb;

  localparam logic [1:0] KIND_NOP   = 2'd3;  // unused kind, block must do nothing
  localparam int         SYS_BIT    = itup_pkg::SYS_INT_BIT_DEF;
  localparam int         UART_BIT   = itup_pkg::UART_INT_BIT_DEF;
  localparam int         RAND_ITEMS = 450;
  localparam int         CYCLE_CAP  = 40000;
  localparam int         N_DIRECTED = 25;

  typedef struct packed {
    itup_pkg::item_t stim;
    logic            fixed;       // read_value typed in below, other fields zero
    logic [31:0]     fixed_read;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = itup_pkg::KIND_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  // Register image kept by the predictor
  logic [31:0] pend, ena, period_reload, period_count, ser_status;
  logic [4:0]  last_vec;
  logic [3:0]  tmr_status, tmr_int_en;
  logic [19:0] ser_int_en;
  logic [7:0]  rx_hold;
  logic [31:0] tmr_aux [4];
  logic [31:0] ser_aux [7];

  itup_pkg::result_t awaited_results [$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          long_stall_go = 1'b0;
  bit          long_stall_done = 1'b0;
  int          stall_left = 0;
  dir_row_t    dir_rows [N_DIRECTED];

  interrupt_timer_uart_peripheral i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Applies one transaction to the register image and returns the result it gives
  function automatic itup_pkg::result_t step_registers(input itup_pkg::item_t it);
    itup_pkg::result_t res;
    logic [31:0]       act;
    logic              found;
    res = '0;
    found = 1'b0;
    case (it.kind)
      itup_pkg::KIND_READ: begin
        case (it.reg_index)
          itup_pkg::REG_VECTOR: begin
            // lowest pending bit, masked or not
            for (int i = 0; i < 32; i++) begin
              if (!found && pend[i]) begin
                found = 1'b1;
                res.read_value = 32'(i);
                pend[i] = 1'b0;
              end
            end
            last_vec = res.read_value[4:0];
          end
          itup_pkg::REG_LAST_VECTOR:   res.read_value = {27'd0, last_vec};
          itup_pkg::REG_ENABLE_A,
          itup_pkg::REG_ENABLE_B:      res.read_value = ena;
          itup_pkg::REG_PERIOD:        res.read_value = period_reload;
          itup_pkg::REG_WD_MODE:       res.read_value = tmr_aux[1];
          itup_pkg::REG_RT_MODE:       res.read_value = tmr_aux[2];
          itup_pkg::REG_TMR_STATUS: begin
            res.read_value = {28'd0, tmr_status};
            tmr_status = '0;
          end
          itup_pkg::REG_TMR_INT:       res.read_value = {28'd0, tmr_int_en};
          itup_pkg::REG_RT_ALARM:      res.read_value = tmr_aux[3];
          itup_pkg::REG_RT_COUNT,
          itup_pkg::REG_ERR_COUNT:     res.read_value = '0;
          itup_pkg::REG_SER_MODE:      res.read_value = ser_aux[1];
          itup_pkg::REG_SER_INT:       res.read_value = {12'd0, ser_int_en};
          itup_pkg::REG_SER_STATUS:    res.read_value = ser_status;
          itup_pkg::REG_RX_HOLD: begin
            ser_status[0] = 1'b0;
            res.read_value = {24'd0, rx_hold};
          end
          itup_pkg::REG_BAUD, itup_pkg::REG_RX_TMO,
          itup_pkg::REG_TX_GUARD, itup_pkg::REG_FIDI:
            res.read_value = ser_aux[3'(it.reg_index - itup_pkg::REG_RX_HOLD)];
          itup_pkg::REG_SER_IF:        res.read_value = ser_aux[6];
          default:                     res.read_value = itup_pkg::UNMAPPED_READ;
        endcase
      end
      itup_pkg::KIND_WRITE: begin
        case (it.reg_index)
          itup_pkg::REG_ENABLE_SET:   ena = ena | it.write_value;
          itup_pkg::REG_ENABLE_CLR:   ena = ena & ~it.write_value;
          itup_pkg::REG_PEND_CLR,
          itup_pkg::REG_EOI:          pend = pend & ~it.write_value;
          itup_pkg::REG_TMR_CTRL:     tmr_aux[0] = it.write_value;
          itup_pkg::REG_PERIOD: begin
            period_reload = it.write_value;
            period_count = it.write_value;
          end
          itup_pkg::REG_WD_MODE:      tmr_aux[1] = it.write_value;
          itup_pkg::REG_RT_MODE:      tmr_aux[2] = it.write_value;
          itup_pkg::REG_TMR_INT_SET: begin
            tmr_int_en = tmr_int_en | it.write_value[3:0];
            if (tmr_int_en != '0) pend[SYS_BIT] = 1'b1;
          end
          itup_pkg::REG_TMR_INT_CLR:  tmr_int_en = tmr_int_en & ~it.write_value[3:0];
          itup_pkg::REG_RT_ALARM:     tmr_aux[3] = it.write_value;
          itup_pkg::REG_SER_CTRL:     ser_aux[0] = it.write_value;
          itup_pkg::REG_SER_MODE:     ser_aux[1] = it.write_value;
          itup_pkg::REG_SER_INT_SET: begin
            ser_int_en = ser_int_en | (it.write_value[19:0] & itup_pkg::SER_INT_MASK);
            if (ser_int_en != '0) pend[UART_BIT] = 1'b1;
          end
          itup_pkg::REG_SER_INT_CLR:
            ser_int_en = ser_int_en & ~it.write_value[19:0] & itup_pkg::SER_INT_MASK;
          itup_pkg::REG_TX: begin
            res.tx_valid = 1'b1;
            res.tx_byte = it.write_value[7:0];
            ser_status[1] = 1'b1;
          end
          itup_pkg::REG_BAUD, itup_pkg::REG_RX_TMO,
          itup_pkg::REG_TX_GUARD, itup_pkg::REG_FIDI:
            ser_aux[3'(it.reg_index - itup_pkg::REG_RX_HOLD)] = it.write_value;
          itup_pkg::REG_SER_IF:       ser_aux[6] = it.write_value;
          default: ;
        endcase
      end
      itup_pkg::KIND_TICK: begin
        // timer frozen while the period is zero
        if (period_reload != '0) begin
          if (period_count == '0) begin
            tmr_status[0] = 1'b1;
            if (tmr_int_en[0]) pend[SYS_BIT] = 1'b1;
            period_count = period_reload;
          end else begin
            period_count = period_count - 32'd1;
          end
        end
        if (ser_int_en[0] && it.rx_valid) begin
          rx_hold = it.rx_byte;
          ser_status[0] = 1'b1;
          pend[UART_BIT] = 1'b1;
        end
      end
      default: ;
    endcase
    act = pend & ena;
    res.irq_active = |(act & itup_pkg::IRQ_MASK);
    res.fiq_active = act[0];
    return res;
  endfunction

  // Offers one transaction, waits for acceptance and queues its expected result
  task automatic send_transaction(input itup_pkg::item_t it, input logic fixed,
                                  input logic [31:0] fixed_read);
    itup_pkg::result_t want;
    while (!quiet && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.rx_byte, it.rx_valid, it.write_value, it.reg_index};
    s_axis_tuser  <= it.kind;
    do @(posedge clk); while (!s_axis_tready);
    want = step_registers(it);
    if (fixed) begin
      want = '0;
      want.read_value = fixed_read;
    end
    awaited_results.push_back(want);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (long_stall_go && !long_stall_done) begin
      stall_left = 48;
      long_stall_done = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    itup_pkg::result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.read_value = m_axis_tdata[31:0];
      got.irq_active = m_axis_tdata[32];
      got.fiq_active = m_axis_tdata[33];
      got.tx_valid   = m_axis_tdata[34];
      got.tx_byte    = m_axis_tdata[42:35];
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, got.read_value);
          mismatches++;
        end
        if (got.irq_active !== want.irq_active) begin
          $error("irq_active: expected %b, got %b", want.irq_active, got.irq_active);
          mismatches++;
        end
        if (got.fiq_active !== want.fiq_active) begin
          $error("fiq_active: expected %b, got %b", want.fiq_active, got.fiq_active);
          mismatches++;
        end
        if (got.tx_valid !== want.tx_valid) begin
          $error("tx_valid: expected %b, got %b", want.tx_valid, got.tx_valid);
          mismatches++;
        end
        if (got.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("interrupt_timer_uart_peripheral_tb failed");
      $finish;
    end
  end

  initial begin
    itup_pkg::item_t it;
    int              pick;

    pend = '0;
    ena = '0;
    last_vec = '0;
    period_reload = '0;
    period_count = '0;
    tmr_status = '0;
    tmr_int_en = '0;
    ser_status = itup_pkg::SER_STATUS_RST;
    ser_int_en = '0;
    rx_hold = '0;
    for (int i = 0; i < 4; i++) tmr_aux[i] = '0;
    for (int i = 0; i < 7; i++) ser_aux[i] = '0;
    ser_aux[1] = itup_pkg::SER_MODE_RST;
    ser_aux[2] = itup_pkg::SER_MODE_RST;

    dir_rows = '{
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_SER_STATUS,  32'h0,        1'b0, 8'h00},
        1'b1, itup_pkg::SER_STATUS_RST},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_SER_MODE,    32'h0,        1'b0, 8'h00},
        1'b1, itup_pkg::SER_MODE_RST},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_BAUD,        32'h0,        1'b0, 8'h00},
        1'b1, itup_pkg::SER_MODE_RST},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_VECTOR,      32'h0,        1'b0, 8'h00},
        1'b1, 32'h0},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_ENABLE_SET,  32'h0,        1'b0, 8'h00},
        1'b1, itup_pkg::UNMAPPED_READ},
      '{'{KIND_NOP,             itup_pkg::REG_SER_IF,      32'hffffffff, 1'b1, 8'hff},
        1'b1, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_RT_COUNT,    32'hffffffff, 1'b0, 8'h00},
        1'b1, 32'h0},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_RT_COUNT,    32'h0,        1'b0, 8'h00},
        1'b1, 32'h0},
      // receive disabled: byte dropped
      '{'{itup_pkg::KIND_TICK,  itup_pkg::REG_VECTOR,      32'h0,        1'b1, 8'ha5},
        1'b1, 32'h0},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_RX_HOLD,     32'h0,        1'b0, 8'h00},
        1'b1, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_ENABLE_SET,  32'hffffffff, 1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_TMR_INT_SET, 32'hffffffff, 1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_SER_INT_SET, 32'hffffffff, 1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_TICK,  itup_pkg::REG_SER_IF,      32'h0,        1'b1, 8'hff},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_RX_HOLD,     32'h0,        1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_TX,          32'hffffffff, 1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_PERIOD,      32'h1,        1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_TICK,  itup_pkg::REG_VECTOR,      32'h0,        1'b0, 8'h00},
        1'b0, 32'h0},
      // count now zero: expiry on this tick
      '{'{itup_pkg::KIND_TICK,  itup_pkg::REG_VECTOR,      32'h0,        1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_TMR_STATUS,  32'h0,        1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_TMR_STATUS,  32'h0,        1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_READ,  itup_pkg::REG_VECTOR,      32'h0,        1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_PEND_CLR,    32'hffffffff, 1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_PERIOD,      32'hffffffff, 1'b0, 8'h00},
        1'b0, 32'h0},
      '{'{itup_pkg::KIND_WRITE, itup_pkg::REG_ENABLE_CLR,  32'hfffffffe, 1'b0, 8'h00},
        1'b0, 32'h0}
    };

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int n = 0; n < N_DIRECTED; n++) begin
      send_transaction(dir_rows[n].stim, dir_rows[n].fixed, dir_rows[n].fixed_read);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 100) long_stall_go = 1'b1;
      quiet = (n >= 250 && n < 330);
      if (n == 380) begin
        // let the pipeline drain completely before carrying on
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (awaited_results.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 34)      it.kind = itup_pkg::KIND_READ;
      else if (pick < 68) it.kind = itup_pkg::KIND_WRITE;
      else if (pick < 98) it.kind = itup_pkg::KIND_TICK;
      else                it.kind = KIND_NOP;
      it.reg_index = 5'($urandom_range(0, 31));
      it.write_value = $urandom;
      // short periods so the timer expires often
      if (it.kind == itup_pkg::KIND_WRITE && it.reg_index == itup_pkg::REG_PERIOD &&
          $urandom_range(0, 7) != 0)
        it.write_value = $urandom_range(0, 5);
      it.rx_valid = 1'($urandom_range(0, 1));
      it.rx_byte = 8'($urandom_range(0, 255));
      send_transaction(it, 1'b0, 32'h0);
    end

    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("interrupt_timer_uart_peripheral_tb passed");
    end else begin
      $display("interrupt_timer_uart_peripheral_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/itup_pkg.sv
rtl/core/itup_regs.sv
rtl/core/interrupt_timer_uart_peripheral.sv
rtl/core/itup_checker.sv
tb/interrupt_timer_uart_peripheral_tb.sv
